FILE: rtl/lpcb_pkg.sv
// Package for the lidar point / camera box gate: field widths, payload types,
// codes and the shared-unit request type. Depends on nothing.
package lpcb_pkg;

    // Field widths fixed by the item format
    localparam int COORD_W      = 20;
    localparam int COEFF_W      = 32;
    localparam int COEFF_IDX_W  = 4;
    localparam int BOX_FIELD_W  = 16;
    localparam int NUM_COEFF    = 12;
    localparam int LAST_COEFF   = NUM_COEFF - 1;

    localparam int COEFF_FRAC_BITS   = 16;
    localparam int MAX_BOXES_DEFAULT = 16;

    // Shared multiply-accumulate unit widths
    localparam int A_W      = COEFF_W;          // coefficient or depth slice
    localparam int B_W      = COORD_W;          // coordinate or box bound
    localparam int P_W      = A_W + B_W;        // product
    localparam int SUM_W    = P_W + 2;          // row sum of three products and offset
    localparam int ACC_W    = SUM_W + B_W + 6;  // 32*s - bound*depth, exact
    localparam int SZ_SPLIT = 28;               // depth split into low / high slices
    localparam int LHS_SHIFT = 5;               // bounds are in 1/32 pixel

    localparam logic signed [SUM_W-1:0] DEPTH_MIN =
        SUM_W'(64'sd10 <<< COEFF_FRAC_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    localparam cfg_idx_t CFG_FILTER_ENABLE   = 1'd0;
    localparam cfg_idx_t CFG_KEEP_WHEN_EMPTY = 1'd1;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_COEFF = 2'd1,
        CMD_BOX   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                      command;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [COEFF_IDX_W-1:0]    coeff_index;
        logic signed [COEFF_W-1:0] coeff_value;
        logic [BOX_FIELD_W-1:0]    box_center_u;
        logic [BOX_FIELD_W-1:0]    box_center_v;
        logic [BOX_FIELD_W-1:0]    box_width;
        logic [BOX_FIELD_W-1:0]    box_height;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic signed [COORD_W-1:0] kept_z;
        logic                      passed_unfiltered;
    } out_item_t;

    typedef struct packed {
        logic [BOX_FIELD_W-1:0] cu;
        logic [BOX_FIELD_W-1:0] cv;
        logic [BOX_FIELD_W-1:0] w;
        logic [BOX_FIELD_W-1:0] h;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        acc_op_t                 op;
        logic                    hi_shift;   // product weighted by 2^SZ_SPLIT
        logic signed [A_W-1:0]   a;
        logic signed [B_W-1:0]   b;
        logic signed [ACC_W-1:0] load;
    } mac_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_DEPTH,
        ST_BOX_READ,
        ST_TEST,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/lpcb_stream_if.sv
// Valid/ready stream interface with a typed payload, used for both channels.
// Depends on nothing; the payload type is given at instantiation.
interface lpcb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lidar_point_camera_box_gate.sv
// Lidar point gate against camera boxes: top level with sequencer, tables and
// handshake. Depends on lpcb_pkg, lpcb_stream_if, lpcb_ram and lpcb_mac.
//
// Each request on the points channel is a point, a projection coefficient
// write, a box add or a box clear; only points give a result, and only when
// kept. The block takes one request at a time: ready is high only while the
// sequencer is idle. Coefficient writes, box adds and clears are applied
// when taken. A point that passes unfiltered (filter off, table not
// calibrated, or no boxes with keep_when_empty set) goes straight to the
// emit state. A point that is gated runs through one shared 32x20
// multiplier and an 80-bit accumulator: the three row sums (five steps
// per row), the depth check, then per box examined a box RAM read plus a
// load, two subtracts and a sign check for each of up to four bound tests
// (a test that fails ends that box), and a last step to post the result.
// The result sits in an output register, so the block goes back to idle
// while the result waits, unless the previous result has not been taken
// yet. The box table is a RAM of MAX_BOXES entries; entries beyond the box
// count are never tested.
module lidar_point_camera_box_gate #(
    parameter int MAX_BOXES = lpcb_pkg::MAX_BOXES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  lpcb_pkg::cfg_idx_t     cfg_index,
    input  lpcb_pkg::cfg_data_t    cfg_data,
    lpcb_stream_if.sink            points,
    lpcb_stream_if.source          kept
);
    import lpcb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    // Control and configuration state
    state_t             state_reg, state_next;
    logic [1:0]         row_reg, row_next;
    logic [2:0]         step_reg, step_next;
    logic [1:0]         test_reg, test_next;
    logic [CNT_W-1:0]   box_idx_reg, box_idx_next;
    logic               passed_reg, passed_next;
    logic               out_valid_reg, out_valid_next;
    logic               filter_en_reg;
    logic               keep_empty_reg;
    logic               calibrated_reg;
    logic [CNT_W-1:0]   box_count_reg;
    logic signed [COEFF_W-1:0] coeff_reg [NUM_COEFF];

    // Payload state
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [SUM_W-1:0]   su_reg, su_next;
    logic signed [SUM_W-1:0]   sv_reg, sv_next;
    logic signed [SUM_W-1:0]   sz_reg, sz_next;
    out_item_t                 out_reg;

    logic                    accept;
    logic                    pass_all;
    logic                    box_room;
    logic                    out_load;
    mac_req_t                mac_req;
    logic signed [ACC_W-1:0] acc;
    logic signed [SUM_W-1:0] acc_sum;
    logic [1:0]              coeff_col;
    logic [COEFF_IDX_W-1:0]  coeff_idx;
    logic signed [COEFF_W-1:0] coeff_rd;
    logic [BOX_W-1:0]        ram_rdata;
    box_t                    box_rd;
    logic signed [B_W-1:0]   bound;
    logic signed [A_W-1:0]   sz_lo, sz_hi;
    logic [CNT_W-1:0]        box_idx_inc;
    logic                    acc_neg, acc_zero, test_pass;

    assign accept   = points.valid && points.ready;
    assign points.ready = (state_reg == ST_IDLE);
    assign kept.valid   = out_valid_reg;
    assign kept.data    = out_reg;

    assign pass_all = !filter_en_reg || !calibrated_reg
                      || ((box_count_reg == '0) && keep_empty_reg);
    assign box_room = (box_count_reg < CNT_W'(MAX_BOXES));

    // Box table
    lpcb_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (accept && (points.data.command == CMD_BOX) && box_room),
        .waddr (box_count_reg[ADDR_W-1:0]),
        .wdata ({points.data.box_center_u, points.data.box_center_v,
                 points.data.box_width, points.data.box_height}),
        .raddr (box_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    lpcb_mac u_mac (
        .clk (clk),
        .req (mac_req),
        .acc (acc)
    );

    // Row step 0 fetches the offset column, steps 1..3 the x, y, z columns
    assign coeff_col = (step_reg == 3'd0) ? 2'd3 : 2'(step_reg - 3'd1);
    assign coeff_idx = {row_reg, coeff_col};
    assign coeff_rd  = coeff_reg[coeff_idx];
    assign acc_sum   = acc[SUM_W-1:0];

    // Box bounds in 1/32 pixel: 2*center -/+ size
    assign box_rd = box_t'(ram_rdata);
    always_comb
    begin
        case (test_reg)
            2'd0:    bound = B_W'({box_rd.cu, 1'b0}) - B_W'(box_rd.w);
            2'd1:    bound = B_W'({box_rd.cu, 1'b0}) + B_W'(box_rd.w);
            2'd2:    bound = B_W'({box_rd.cv, 1'b0}) - B_W'(box_rd.h);
            default: bound = B_W'({box_rd.cv, 1'b0}) + B_W'(box_rd.h);
        endcase
    end

    // Depth split so each slice fits the multiplier's wide operand
    assign sz_lo = $signed({{(A_W-SZ_SPLIT){1'b0}}, sz_reg[SZ_SPLIT-1:0]});
    assign sz_hi = A_W'(sz_reg >>> SZ_SPLIT);

    assign box_idx_inc = box_idx_reg + 1'b1;
    assign acc_neg     = acc[ACC_W-1];
    assign acc_zero    = (acc == '0);
    // even tests are lower bounds (diff >= 0), odd tests upper bounds (diff <= 0)
    assign test_pass   = test_reg[0] ? (acc_neg || acc_zero) : !acc_neg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        step_next      = step_reg;
        test_next      = test_reg;
        box_idx_next   = box_idx_reg;
        passed_next    = passed_reg;
        su_next        = su_reg;
        sv_next        = sv_reg;
        sz_next        = sz_reg;
        out_valid_next = out_valid_reg && !kept.ready;
        out_load       = 1'b0;
        mac_req        = '0;
        mac_req.op     = ACC_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (points.data.command == CMD_POINT))
                begin
                    if (pass_all)
                    begin
                        passed_next = 1'b1;
                        state_next  = ST_EMIT;
                    end
                    else if (box_count_reg != '0)
                    begin
                        row_next   = 2'd0;
                        step_next  = 3'd0;
                        state_next = ST_ROW;
                    end
                end
            end

            ST_ROW:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        // offset starts the row; previous row's sum is final
                        mac_req.op   = ACC_LOAD;
                        mac_req.load = ACC_W'(coeff_rd);
                        case (row_reg)
                            2'd1:    su_next = acc_sum;
                            2'd2:    sv_next = acc_sum;
                            default: ;
                        endcase
                    end
                    3'd1:
                    begin
                        mac_req.a = coeff_rd;
                        mac_req.b = px_reg;
                    end
                    3'd2:
                    begin
                        mac_req.op = ACC_ADD;
                        mac_req.a  = coeff_rd;
                        mac_req.b  = py_reg;
                    end
                    3'd3:
                    begin
                        mac_req.op = ACC_ADD;
                        mac_req.a  = coeff_rd;
                        mac_req.b  = pz_reg;
                    end
                    default:
                    begin
                        mac_req.op = ACC_ADD;
                        step_next  = 3'd0;
                        if (row_reg == 2'd2)
                        begin
                            state_next = ST_DEPTH;
                        end
                        else
                        begin
                            row_next = row_reg + 2'd1;
                        end
                    end
                endcase
            end

            ST_DEPTH:
            begin
                sz_next = acc_sum;
                if (acc_sum > DEPTH_MIN)
                begin
                    box_idx_next = '0;
                    state_next   = ST_BOX_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_BOX_READ:
            begin
                // RAM read of box_idx lands next cycle
                test_next  = 2'd0;
                step_next  = 3'd0;
                state_next = ST_TEST;
            end

            ST_TEST:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        mac_req.op   = ACC_LOAD;
                        mac_req.load = test_reg[1] ? (ACC_W'(sv_reg) <<< LHS_SHIFT)
                                                   : (ACC_W'(su_reg) <<< LHS_SHIFT);
                        mac_req.a    = sz_lo;
                        mac_req.b    = bound;
                    end
                    3'd1:
                    begin
                        mac_req.op = ACC_SUB;
                        mac_req.a  = sz_hi;
                        mac_req.b  = bound;
                    end
                    3'd2:
                    begin
                        mac_req.op       = ACC_SUB;
                        mac_req.hi_shift = 1'b1;
                    end
                    default:
                    begin
                        step_next = 3'd0;
                        if (test_pass)
                        begin
                            if (test_reg == 2'd3)
                            begin
                                passed_next = 1'b0;
                                state_next  = ST_EMIT;
                            end
                            else
                            begin
                                test_next = test_reg + 2'd1;
                            end
                        end
                        else if (box_idx_inc == box_count_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            box_idx_next = box_idx_inc;
                            state_next   = ST_BOX_READ;
                        end
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || kept.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, configuration and tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            step_reg       <= '0;
            test_reg       <= '0;
            box_idx_reg    <= '0;
            passed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            filter_en_reg  <= 1'b1;
            keep_empty_reg <= 1'b1;
            calibrated_reg <= 1'b0;
            box_count_reg  <= '0;
            for (int i = 0; i < NUM_COEFF; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            step_reg      <= step_next;
            test_reg      <= test_next;
            box_idx_reg   <= box_idx_next;
            passed_reg    <= passed_next;
            out_valid_reg <= out_valid_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_ENABLE:   filter_en_reg  <= cfg_data[0];
                    CFG_KEEP_WHEN_EMPTY: keep_empty_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                case (points.data.command)
                    CMD_COEFF:
                    begin
                        if (points.data.coeff_index < COEFF_IDX_W'(NUM_COEFF))
                        begin
                            coeff_reg[points.data.coeff_index] <= points.data.coeff_value;
                            if (points.data.coeff_index == COEFF_IDX_W'(LAST_COEFF))
                            begin
                                calibrated_reg <= 1'b1;
                            end
                        end
                    end
                    CMD_BOX:
                    begin
                        if (box_room)
                        begin
                            box_count_reg <= box_count_reg + 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        box_count_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= points.data.coord_x;
            py_reg <= points.data.coord_y;
            pz_reg <= points.data.coord_z;
        end
        su_reg <= su_next;
        sv_reg <= sv_next;
        sz_reg <= sz_next;
        if (out_load)
        begin
            out_reg.kept_x            <= px_reg;
            out_reg.kept_y            <= py_reg;
            out_reg.kept_z            <= pz_reg;
            out_reg.passed_unfiltered <= passed_reg;
        end
    end
endmodule

FILE: rtl/lpcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lpcb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/lpcb_mac.sv
// Shared multiply-accumulate unit: registered 32x20 signed product, then a wide
// accumulator that adds or subtracts it, or loads a value. Depends on lpcb_pkg.
module lpcb_mac (
    input  logic                             clk,
    input  lpcb_pkg::mac_req_t               req,
    output logic signed [lpcb_pkg::ACC_W-1:0] acc
);
    import lpcb_pkg::*;

    logic signed [P_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] term;

    always_comb
    begin
        term = {{(ACC_W-P_W){prod_reg[P_W-1]}}, prod_reg};
        if (req.hi_shift)
        begin
            term = term <<< SZ_SPLIT;
        end
        case (req.op)
            ACC_LOAD: acc_next = req.load;
            ACC_ADD:  acc_next = acc_reg + term;
            ACC_SUB:  acc_next = acc_reg - term;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;
endmodule

FILE: dv/lidar_point_camera_box_gate_test.sv
// Self-checking testbench for lidar_point_camera_box_gate: feeds point,
// coefficient, box and clear requests and checks every kept point against
// a local model. Depends on lpcb_pkg, lpcb_stream_if and the gate itself.
module lidar_point_camera_box_gate_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpcb_pkg::*;

    localparam int BOX_CAP      = MAX_BOXES_DEFAULT;
    // Drain wait covers the longest gated point plus margin for the output register
    localparam int DRAIN_CYCLES = 18 + 17 * BOX_CAP + 20;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int REPORT_MAX   = 10;
    localparam int Q_ONE        = 1 << COEFF_FRAC_BITS;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    lpcb_stream_if #(.payload_t(in_item_t))  pts_ch ();
    lpcb_stream_if #(.payload_t(out_item_t)) keep_ch ();

    lidar_point_camera_box_gate #(.MAX_BOXES(BOX_CAP)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (pts_ch),
        .kept      (keep_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Gate model: projection table, calibration flag, box table, registers
    // ------------------------------------------------------------------
    logic signed [COEFF_W-1:0] proj_tab [NUM_COEFF];
    bit        calib;
    box_t      box_tab [BOX_CAP];
    int        box_cnt;
    bit        filt_on;
    bit        keep_empty;
    out_item_t kept_expect [$];

    int        mismatches;
    int        cycles;

    // Request stream feeding the driver, plus idle knobs for both sides
    in_item_t  req_q [$];
    bit        req_taken;
    int        tx_idle_pct;
    int        rx_stall_pct;

    // What the stimulus side believes is loaded, so points can be aimed at
    // boxes. Noise requests may make this stale; that is fine.
    int        cam_fx;
    int        cam_cx;
    int        cam_cy;
    int        cam_t;
    bit        cam_ok;
    box_t      scene_boxes [$];
    int        planned;

    // Exact inclusive span test with no division: 32*s against bound*depth.
    // Products reach about 2^73, so the compare runs at 96 bits.
    function automatic bit in_span(longint s, longint lo, longint hi, longint d);
        logic signed [95:0] lhs;
        logic signed [95:0] sd;
        lhs = s;
        lhs = lhs <<< LHS_SHIFT;
        sd  = d;
        return (lhs >= lo * sd) && (lhs <= hi * sd);
    endfunction

    // Applies one accepted request to the model; a kept point is queued.
    function automatic void gate_request(in_item_t r);
        longint    pt [3];
        longint    row_sum [3];
        longint    ulo;
        longint    uhi;
        longint    vlo;
        longint    vhi;
        bit        unfiltered;
        bit        hit;
        int        k;
        int        j;
        out_item_t res;
        case (r.command)
            CMD_COEFF:
            begin
                // index 12..15 is silently dropped
                if (r.coeff_index < NUM_COEFF)
                begin
                    proj_tab[r.coeff_index] = r.coeff_value;
                    if (r.coeff_index == LAST_COEFF)
                        calib = 1'b1;
                end
            end
            CMD_BOX:
            begin
                // table full: the box is lost
                if (box_cnt < BOX_CAP)
                begin
                    box_tab[box_cnt] = box_t'{cu: r.box_center_u, cv: r.box_center_v,
                                             w: r.box_width, h: r.box_height};
                    box_cnt++;
                end
            end
            CMD_CLEAR:
                box_cnt = 0;
            default:
            begin
                unfiltered = !filt_on || !calib || (box_cnt == 0 && keep_empty);
                hit = 1'b0;
                if (!unfiltered && box_cnt != 0)
                begin
                    pt[0] = longint'(r.coord_x);
                    pt[1] = longint'(r.coord_y);
                    pt[2] = longint'(r.coord_z);
                    for (k = 0; k < 3; k++)
                    begin
                        row_sum[k] = longint'(proj_tab[4 * k + 3]);
                        for (j = 0; j < 3; j++)
                            row_sum[k] += longint'(proj_tab[4 * k + j]) * pt[j];
                    end
                    // depth must be strictly beyond 10 mm
                    if (row_sum[2] > (longint'(10) <<< COEFF_FRAC_BITS))
                    begin
                        for (k = 0; k < box_cnt && !hit; k++)
                        begin
                            ulo = 2 * longint'(box_tab[k].cu) - longint'(box_tab[k].w);
                            uhi = 2 * longint'(box_tab[k].cu) + longint'(box_tab[k].w);
                            vlo = 2 * longint'(box_tab[k].cv) - longint'(box_tab[k].h);
                            vhi = 2 * longint'(box_tab[k].cv) + longint'(box_tab[k].h);
                            hit = in_span(row_sum[0], ulo, uhi, row_sum[2])
                                  && in_span(row_sum[1], vlo, vhi, row_sum[2]);
                        end
                    end
                end
                if (unfiltered || hit)
                begin
                    res.kept_x = r.coord_x;
                    res.kept_y = r.coord_y;
                    res.kept_z = r.coord_z;
                    res.passed_unfiltered = unfiltered;
                    kept_expect.insert(kept_expect.size(), res);
                end
            end
        endcase
    endfunction

    function automatic void flag_mismatch(string what, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch (%s): want x=%0d y=%0d z=%0d u=%0b, got x=%0d y=%0d z=%0d u=%0b",
                     what, want.kept_x, want.kept_y, want.kept_z, want.passed_unfiltered,
                     got.kept_x, got.kept_y, got.kept_z, got.passed_unfiltered);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge, holds a request until it
    // is taken, then either presents the next one or idles.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!pts_ch.valid || req_taken))
        begin
            req_taken = 1'b0;
            if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                pts_ch.data  <= req_q.pop_front();
                pts_ch.valid <= 1'b1;
            end
            else
                pts_ch.valid <= 1'b0;
        end
        keep_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Request acceptance: the model runs on exactly what the block took
    always @(posedge clk)
    begin
        if (rst_n && pts_ch.valid && pts_ch.ready)
        begin
            gate_request(pts_ch.data);
            req_taken = 1'b1;
        end
    end

    // Kept-point monitor: compares each result with the oldest prediction
    always @(posedge clk)
    begin : kept_monitor
        out_item_t want;
        out_item_t got;
        if (rst_n && keep_ch.valid && keep_ch.ready)
        begin
            got = keep_ch.data;
            if (kept_expect.size() == 0)
                flag_mismatch("no point pending", '0, got);
            else
            begin
                want = kept_expect.pop_front();
                if (got.kept_x !== want.kept_x || got.kept_y !== want.kept_y ||
                    got.kept_z !== want.kept_z ||
                    got.passed_unfiltered !== want.passed_unfiltered)
                    flag_mismatch("field", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Request of the given kind with every other field random, so unused
    // fields toggle too.
    function automatic in_item_t any_req(cmd_t c);
        in_item_t r;
        r.command      = c;
        r.coord_x      = COORD_W'($urandom);
        r.coord_y      = COORD_W'($urandom);
        r.coord_z      = COORD_W'($urandom);
        r.coeff_index  = COEFF_IDX_W'($urandom);
        r.coeff_value  = COEFF_W'($urandom);
        r.box_center_u = BOX_FIELD_W'($urandom);
        r.box_center_v = BOX_FIELD_W'($urandom);
        r.box_width    = BOX_FIELD_W'($urandom);
        r.box_height   = BOX_FIELD_W'($urandom);
        return r;
    endfunction

    function automatic void push_req(in_item_t r);
        req_q.insert(req_q.size(), r);
        case (r.command)
            CMD_COEFF:
                if (r.coeff_index < NUM_COEFF)
                    cam_ok = 1'b0;
            CMD_BOX:
                if (scene_boxes.size() < BOX_CAP)
                    scene_boxes.insert(scene_boxes.size(),
                                       box_t'{cu: r.box_center_u, cv: r.box_center_v,
                                              w: r.box_width, h: r.box_height});
            CMD_CLEAR:
                scene_boxes.delete();
            default: ;
        endcase
        // writes to a missing coefficient are ignored by the block
        if (!(r.command == CMD_COEFF && r.coeff_index >= NUM_COEFF))
            planned++;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return COORD_W'(v);
    endfunction

    function automatic void push_point(longint x, longint y, longint z);
        in_item_t r;
        r = any_req(CMD_POINT);
        r.coord_x = COORD_W'(x);
        r.coord_y = COORD_W'(y);
        r.coord_z = COORD_W'(z);
        push_req(r);
    endfunction

    function automatic void push_coeff(int idx, int val);
        in_item_t r;
        r = any_req(CMD_COEFF);
        r.coeff_index = COEFF_IDX_W'(idx);
        r.coeff_value = val;
        push_req(r);
    endfunction

    function automatic void push_box(int cu, int cv, int w, int h);
        in_item_t r;
        r = any_req(CMD_BOX);
        r.box_center_u = BOX_FIELD_W'(cu);
        r.box_center_v = BOX_FIELD_W'(cv);
        r.box_width    = BOX_FIELD_W'(w);
        r.box_height   = BOX_FIELD_W'(h);
        push_req(r);
    endfunction

    // Pinhole camera down lidar +x: u = (cx*x - fx*y)/d, v = (cy*x - fx*z)/d,
    // depth d = x + t. The last write (translation of the depth row) calibrates.
    function automatic void load_camera(int fx, int cx, int cy, int t);
        push_coeff(0, cx * Q_ONE);
        push_coeff(1, -fx * Q_ONE);
        push_coeff(2, 0);
        push_coeff(3, 0);
        push_coeff(4, cy * Q_ONE);
        push_coeff(5, 0);
        push_coeff(6, -fx * Q_ONE);
        push_coeff(7, 0);
        push_coeff(8, Q_ONE);
        push_coeff(9, 0);
        push_coeff(10, 0);
        push_coeff(LAST_COEFF, t * Q_ONE);
        cam_fx = fx;
        cam_cx = cx;
        cam_cy = cy;
        cam_t  = t;
        cam_ok = 1'b1;
    endfunction

    // Mostly points aimed near stored boxes (about a quarter land inside), with
    // box sets, camera reloads, clears and some raw noise mixed in.
    task automatic fill_random(int n);
        int     pick;
        int     k;
        int     nbox;
        longint x;
        longint tu;
        longint tv;
        longint y;
        longint z;
        box_t   b;
        planned = 0;
        while (planned < n)
        begin
            pick = $urandom_range(99);
            if ((!cam_ok && pick < 40) || pick < 3)
                load_camera($urandom_range(900, 200), $urandom_range(440, 200),
                            $urandom_range(330, 150), int'($urandom_range(200)) - 100);
            else if (pick < 11)
                push_req(any_req(cmd_t'($urandom_range(3))));
            else if (pick < 17)
            begin
                if ($urandom_range(1) == 1)
                    push_req(any_req(CMD_CLEAR));
                // now and then overfill the table
                nbox = ($urandom_range(9) == 0) ? $urandom_range(19, 15) : $urandom_range(5, 1);
                for (k = 0; k < nbox; k++)
                    push_box($urandom_range(640 * 16), $urandom_range(480 * 16),
                             $urandom_range(3000), $urandom_range(3000));
            end
            else if (pick < 19)
                push_req(any_req(CMD_CLEAR));
            else if (pick < 28 || scene_boxes.size() == 0)
            begin
                x = $urandom_range(20000, 100);
                push_point(x, longint'($urandom_range(2 * x)) - x,
                           longint'($urandom_range(2 * x)) - x);
            end
            else
            begin
                b  = scene_boxes[$urandom_range(scene_boxes.size() - 1)];
                tu = longint'(b.cu) - longint'(b.w) + longint'($urandom_range(2 * b.w));
                tv = longint'(b.cv) - longint'(b.h) + longint'($urandom_range(2 * b.h));
                // some shallow points probe the depth cut
                x  = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(20000, 200);
                y  = (16 * longint'(cam_cx) * x - tu * (x + cam_t)) / (16 * longint'(cam_fx));
                z  = (16 * longint'(cam_cy) * x - tv * (x + cam_t)) / (16 * longint'(cam_fx));
                push_point(x, clamp_coord(y), clamp_coord(z));
            end
        end
    endtask

    // Waits until every request is taken and every kept point has arrived,
    // then lets a dropped point that may still be in flight finish.
    task automatic wait_drained();
        while (req_q.size() != 0 || pts_ch.valid || kept_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, bit val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(val);
        if (idx == CFG_FILTER_ENABLE)
            filt_on = val;
        else
            keep_empty = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block is idle here, so registers can change safely
    task automatic run_phase(bit fe, bit ke, int tx_pct, int rx_pct, int n);
        wait_drained();
        write_reg(CFG_FILTER_ENABLE, fe);
        write_reg(CFG_KEEP_WHEN_EMPTY, ke);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        fill_random(n);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FILTER_ENABLE;
        cfg_data      = '0;
        pts_ch.valid  = 1'b0;
        pts_ch.data   = '0;
        keep_ch.ready = 1'b0;
        foreach (proj_tab[i])
            proj_tab[i] = '0;
        calib        = 1'b0;
        box_cnt      = 0;
        filt_on      = 1'b1;
        keep_empty   = 1'b1;
        mismatches   = 0;
        cycles       = 0;
        req_taken    = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cam_ok       = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values, no idling.
        // Not calibrated yet: every point passes unfiltered.
        push_point(COORD_MAX, COORD_MIN, 0);
        push_box(320 * 16, 240 * 16, 100 * 16, 100 * 16);
        push_coeff(15, int'(32'h8000_0000));
        load_camera(500, 320, 240, 0);
        // Calibrated, one box around the image center
        push_point(1000, 0, 0);              // dead center, kept by the box
        push_point(-1000, 0, 0);             // behind the camera
        push_point(10, 0, 0);                // depth exactly 10 mm, dropped
        push_point(11, 0, 0);                // just past the cut, kept
        push_req(any_req(CMD_CLEAR));
        push_point(2000, 0, 0);              // no boxes with keep set: passes
        // Zero-size box: a single pixel, test stays inclusive
        push_box(320 * 16, 240 * 16, 0, 0);
        push_point(1000, 0, 0);              // lands on it exactly
        push_point(1000, -1, 0);             // half a pixel off
        push_req(any_req(CMD_CLEAR));
        // Field extremes: all-ones box and all-zero box
        push_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_box(0, 0, 0, 0);
        push_point(1000, -5360, -5520);      // u = v = 3000 px, inside the big one
        push_point(1000, 640, 480);          // u = v = 0, on the zero box

        fill_random(120);

        // Register settings and idle patterns
        run_phase(1'b1, 1'b0, 87, 0, 100);
        run_phase(1'b1, 1'b1, 0, 87, 130);
        run_phase(1'b0, 1'b0, 11, 11, 70);
        run_phase(1'b1, 1'b0, 11, 11, 100);
        run_phase(1'b1, 1'b1, 0, 0, 50);

        wait_drained();
        if (mismatches == 0 && kept_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lpcb_pkg.sv
rtl/lpcb_stream_if.sv
rtl/lpcb_ram.sv
rtl/lpcb_mac.sv
rtl/lidar_point_camera_box_gate.sv
dv/lidar_point_camera_box_gate_test.sv
